[src/tsoa_pkg.sv]
// Shared codes and types for the three-stacks-in-one-array block.
`default_nettype none

package tsoa_pkg;

  localparam int DATA_W   = 32;
  localparam int SEL_W    = 2;
  localparam int STATUS_W = 2;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Count update request from the sequencer to the count bank.
  typedef struct packed {
    logic inc;
    logic dec;
  } cnt_cmd_t;

endpackage

`default_nettype wire

[src/tsoa_ram.sv]
// Slot store: one write port, one read port with registered read data.
`default_nettype none

module tsoa_ram import tsoa_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [AW-1:0]     raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[src/tsoa_counts.sv]
// Per-stack element counters with the total over all stacks and the prefix sum up to the selected stack.
`default_nettype none

module tsoa_counts import tsoa_pkg::*; #(
  parameter int NUM_STACKS = 3,
  parameter int CW         = 7
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [SEL_W-1:0] sel,
  input  wire cnt_cmd_t         cmd,
  output logic      [CW-1:0]    total,
  output logic      [CW-1:0]    prefix,
  output logic                  sel_ok,
  output logic                  sel_empty
);

  localparam int IW = 4;

  logic [CW-1:0] counts [NUM_STACKS];
  logic [IW-1:0] sel_w;

  assign sel_w  = IW'(sel);
  assign sel_ok = sel_w < IW'(NUM_STACKS);

  // prefix covers stacks 0..sel inclusive
  always_comb begin
    total     = '0;
    prefix    = '0;
    sel_empty = 1'b1;
    for (int i = 0; i < NUM_STACKS; i++) begin
      total = total + counts[i];
      if (IW'(i) <= sel_w) begin
        prefix = prefix + counts[i];
      end
      if (IW'(i) == sel_w) begin
        sel_empty = counts[i] == '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_STACKS; i++) begin
        counts[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_STACKS; i++) begin
        if (IW'(i) == sel_w) begin
          if (cmd.inc) begin
            counts[i] <= counts[i] + CW'(1);
          end else if (cmd.dec) begin
            counts[i] <= counts[i] - CW'(1);
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

[src/three_stacks_one_array.sv]
// Top level: sequencer that moves slots through the shared store for push and pop.
`default_nettype none

// NUM_STACKS stacks packed back to back in one store of CAPACITY 32-bit slots.
// An item is taken when start is high and busy is low; its single result
// appears with done high for exactly one cycle and must be taken then, since
// the receiver cannot hold it off. A rejected item (empty pop, full push, or a
// stack number that does not exist) finishes in the evaluation state. An
// accepted push or pop moves each slot that lies above the insert or removal
// point (slots of higher stacks plus none of the addressed one): each of those
// slots is moved by one read and one write through the single read/write port
// pair of the slot RAM, one slot per cycle. A push ends with a write of the
// new value, a pop begins with a read of the top value. busy stays high from
// the start edge until the result is produced.
module three_stacks_one_array import tsoa_pkg::*; #(
  parameter int CAPACITY   = 64,
  parameter int NUM_STACKS = 3
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       op,
  input  wire logic        [SEL_W-1:0]    stack_sel,
  input  wire logic signed [DATA_W-1:0]   value,
  output logic                            done,
  output logic signed      [DATA_W-1:0]   popped_value,
  output logic             [STATUS_W-1:0] status
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_EVAL    = 3'd1;
  localparam logic [2:0] S_PUSH_SH = 3'd2;
  localparam logic [2:0] S_PUSH_WR = 3'd3;
  localparam logic [2:0] S_POP_RD  = 3'd4;
  localparam logic [2:0] S_POP_SH  = 3'd5;

  logic [2:0]        state, state_next;
  logic              op_r;
  logic [SEL_W-1:0]  sel_r;
  logic [DATA_W-1:0] val_r;
  logic [CW-1:0]     total_r, total_next;
  logic [AW-1:0]     pos_r, pos_next;
  logic [AW-1:0]     wr_ptr, wr_ptr_next;
  logic [DATA_W-1:0] pop_data, pop_data_next;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;

  cnt_cmd_t          cmd;
  logic [CW-1:0]     cnt_total, cnt_prefix, prefix_m1;
  logic              sel_ok, sel_empty;

  logic              fin;
  logic [STATUS_W-1:0] fin_status;
  logic [DATA_W-1:0] fin_pop;

  tsoa_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tsoa_counts #(
    .NUM_STACKS (NUM_STACKS),
    .CW         (CW)
  ) u_counts (
    .clk       (clk),
    .rst       (rst),
    .sel       (sel_r),
    .cmd       (cmd),
    .total     (cnt_total),
    .prefix    (cnt_prefix),
    .sel_ok    (sel_ok),
    .sel_empty (sel_empty)
  );

  assign busy      = state != S_IDLE;
  assign prefix_m1 = cnt_prefix - CW'(1);

  always_comb begin
    state_next    = state;
    total_next    = total_r;
    pos_next      = pos_r;
    wr_ptr_next   = wr_ptr;
    pop_data_next = pop_data;
    ram_we        = 1'b0;
    ram_waddr     = wr_ptr;
    ram_wdata     = ram_rdata;
    ram_raddr     = '0;
    cmd           = '0;
    fin           = 1'b0;
    fin_status    = ST_OK;
    fin_pop       = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        total_next = cnt_total;
        if (op_r == OP_PUSH) begin
          if (!sel_ok || cnt_total >= CW'(CAPACITY)) begin
            fin        = 1'b1;
            fin_status = ST_FULL;
            state_next = S_IDLE;
          end else begin
            pos_next = cnt_prefix[AW-1:0];
            if (cnt_total == cnt_prefix) begin
              state_next = S_PUSH_WR;
            end else begin
              // move from the top slot downward
              ram_raddr   = cnt_total[AW-1:0] - AW'(1);
              wr_ptr_next = cnt_total[AW-1:0];
              state_next  = S_PUSH_SH;
            end
          end
        end else begin
          if (!sel_ok || sel_empty) begin
            fin        = 1'b1;
            fin_status = ST_EMPTY;
            state_next = S_IDLE;
          end else begin
            pos_next    = prefix_m1[AW-1:0];
            wr_ptr_next = prefix_m1[AW-1:0];
            ram_raddr   = prefix_m1[AW-1:0];
            state_next  = S_POP_RD;
          end
        end
      end
      S_PUSH_SH: begin
        ram_we    = 1'b1;
        ram_waddr = wr_ptr;
        ram_wdata = ram_rdata;
        if (wr_ptr - AW'(1) == pos_r) begin
          state_next = S_PUSH_WR;
        end else begin
          ram_raddr   = wr_ptr - AW'(2);
          wr_ptr_next = wr_ptr - AW'(1);
        end
      end
      S_PUSH_WR: begin
        ram_we     = 1'b1;
        ram_waddr  = pos_r;
        ram_wdata  = val_r;
        cmd.inc    = 1'b1;
        fin        = 1'b1;
        state_next = S_IDLE;
      end
      S_POP_RD: begin
        pop_data_next = ram_rdata;
        if (CW'(wr_ptr) + CW'(1) < total_r) begin
          ram_raddr  = wr_ptr + AW'(1);
          state_next = S_POP_SH;
        end else begin
          cmd.dec    = 1'b1;
          fin        = 1'b1;
          fin_pop    = ram_rdata;
          state_next = S_IDLE;
        end
      end
      S_POP_SH: begin
        ram_we    = 1'b1;
        ram_waddr = wr_ptr;
        ram_wdata = ram_rdata;
        if (CW'(wr_ptr) + CW'(2) < total_r) begin
          ram_raddr   = wr_ptr + AW'(2);
          wr_ptr_next = wr_ptr + AW'(1);
        end else begin
          cmd.dec    = 1'b1;
          fin        = 1'b1;
          fin_pop    = pop_data;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      op_r  <= op;
      sel_r <= stack_sel;
      val_r <= value;
    end
    total_r  <= total_next;
    pos_r    <= pos_next;
    wr_ptr   <= wr_ptr_next;
    pop_data <= pop_data_next;
    if (fin) begin
      status       <= fin_status;
      popped_value <= fin_pop;
    end
  end

endmodule

`default_nettype wire
